// File: sv/multi_turn_encoder_tracker_core_macros.svh
// Assertion helpers shared by the encoder tracker RTL.
`ifndef MULTI_TURN_ENCODER_TRACKER_CORE_MACROS_SVH
`define MULTI_TURN_ENCODER_TRACKER_CORE_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MTET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, including during reset.
`define MTET_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/mtet_pkg.sv
package mtet_pkg;

  localparam int CountsPerTurnDefault = 8192;

  localparam int AngleW   = 13;
  localparam int WordW    = 16;
  localparam int StatusW  = 8;
  localparam int TurnsW   = 16;
  localparam int TotalW   = 30;

  typedef enum logic [0:0] {
    KIND_MEASURE = 1'b0,
    KIND_CAPTURE = 1'b1
  } kind_e;

  // Tracker state carried between transactions.
  typedef struct packed {
    logic [AngleW-1:0]        prev_angle;
    logic [AngleW-1:0]        zero_angle;
    logic signed [TurnsW-1:0] turns;
  } track_state_t;

endpackage

// File: sv/mtet_unwrap.sv
module mtet_unwrap #(
  parameter int COUNTS_PER_TURN = mtet_pkg::CountsPerTurnDefault
) (
  input  mtet_pkg::kind_e                         kind_i,
  input  logic [mtet_pkg::AngleW-1:0]             angle_i,
  input  mtet_pkg::track_state_t                  state_i,
  output mtet_pkg::track_state_t                  state_o,
  output logic signed [mtet_pkg::TotalW-1:0]      unwrapped_o
);

  localparam int HalfTurn = COUNTS_PER_TURN / 2;
  localparam int DiffW    = 18;
  localparam int ProdW    = 34;

  logic signed [DiffW-1:0] half_s;
  logic signed [DiffW-1:0] cpt_s;
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] sum;

  assign half_s = DiffW'(HalfTurn);
  assign cpt_s  = DiffW'(COUNTS_PER_TURN);
  assign diff   = $signed({{(DiffW - mtet_pkg::AngleW){1'b0}}, angle_i})
                - $signed({{(DiffW - mtet_pkg::AngleW){1'b0}}, state_i.prev_angle});

  always_comb begin
    state_o            = state_i;
    state_o.prev_angle = angle_i;
    unique case (kind_i)
      mtet_pkg::KIND_CAPTURE: begin
        state_o.zero_angle = angle_i;
      end
      mtet_pkg::KIND_MEASURE: begin
        // A large upward jump means the angle wrapped backward past zero,
        // a large downward jump means it wrapped forward.
        priority if (diff > half_s) begin
          state_o.turns = state_i.turns - 16'sd1;
        end else if (diff < -half_s) begin
          state_o.turns = state_i.turns + 16'sd1;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  assign prod = state_o.turns * cpt_s;
  assign sum  = prod
              + $signed({{(ProdW - mtet_pkg::AngleW){1'b0}}, angle_i})
              - $signed({{(ProdW - mtet_pkg::AngleW){1'b0}}, state_i.zero_angle});
  assign unwrapped_o = sum[mtet_pkg::TotalW-1:0];

endmodule

// File: sv/multi_turn_encoder_tracker_core.sv
// Multi-turn encoder tracker: unwraps a single-turn rotor angle into a
// signed turn count and a total angle relative to a captured offset.
// The input channel (in_valid_i / in_stall_o) carries one decoded feedback
// frame per transaction. A measurement transaction yields exactly one
// result transaction on the output channel (out_valid_o / out_stall_i);
// an offset capture transaction stores its angle as offset and previous
// angle and yields no result.
// An accepted transaction sits in the input register; a measurement moves on
// into the output register once that is free, and its result is offered
// from there until the receiver takes it.
// Throughput is one transaction per cycle while the receiver does not stall;
// the turn and angle registers update as each transaction leaves the input register.
// When the receiver stalls, the result waits in the output register and
// the input register still takes one more transaction; only when both
// hold an item does in_stall_o rise. Capture transactions never wait on
// the output side. Reset clears the turn counter, previous angle and
// offset to zero and empties both registers.
`include "multi_turn_encoder_tracker_core_macros.svh"

module multi_turn_encoder_tracker_core #(
  parameter int COUNTS_PER_TURN = mtet_pkg::CountsPerTurnDefault
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [0:0]                              kind_i,
  input  logic [mtet_pkg::AngleW-1:0]             angle_raw_i,
  input  logic signed [mtet_pkg::WordW-1:0]       speed_raw_i,
  input  logic signed [mtet_pkg::WordW-1:0]       current_raw_i,
  input  logic [mtet_pkg::StatusW-1:0]            status_byte_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [mtet_pkg::AngleW-1:0]             angle_o,
  output logic signed [mtet_pkg::WordW-1:0]       speed_o,
  output logic signed [mtet_pkg::WordW-1:0]       current_o,
  output logic [mtet_pkg::StatusW-1:0]            status_o,
  output logic signed [mtet_pkg::TurnsW-1:0]      turn_count_o,
  output logic signed [mtet_pkg::TotalW-1:0]      unwrapped_angle_o
);

  // Input register.
  logic                                 s1_valid_q, s1_valid_d;
  mtet_pkg::kind_e                      s1_kind_q;
  logic [mtet_pkg::AngleW-1:0]          s1_angle_q;
  logic signed [mtet_pkg::WordW-1:0]    s1_speed_q;
  logic signed [mtet_pkg::WordW-1:0]    s1_current_q;
  logic [mtet_pkg::StatusW-1:0]         s1_status_q;

  // Tracker state.
  mtet_pkg::track_state_t               state_q, state_d;

  // Output register.
  logic                                 out_valid_q, out_valid_d;
  logic [mtet_pkg::AngleW-1:0]          out_angle_q;
  logic signed [mtet_pkg::WordW-1:0]    out_speed_q;
  logic signed [mtet_pkg::WordW-1:0]    out_current_q;
  logic [mtet_pkg::StatusW-1:0]         out_status_q;
  logic signed [mtet_pkg::TurnsW-1:0]   out_turns_q;
  logic signed [mtet_pkg::TotalW-1:0]   out_total_q;

  logic                                 s1_is_meas;
  logic                                 out_free;
  logic                                 s1_move;
  logic                                 s1_load;
  logic                                 out_load;
  logic signed [mtet_pkg::TotalW-1:0]   unwrapped_angle;

  // Handshake control. A measurement leaves the input register only when
  // the output register is empty or being drained this cycle.
  assign s1_is_meas  = (s1_kind_q == mtet_pkg::KIND_MEASURE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_move     = s1_valid_q && (!s1_is_meas || out_free);
  assign in_stall_o  = s1_valid_q && !s1_move;
  assign s1_load     = in_valid_i && !in_stall_o;
  assign out_load    = s1_move && s1_is_meas;
  assign s1_valid_d  = s1_load || (s1_valid_q && !s1_move);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  mtet_unwrap #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN)
  ) u_unwrap (
    .kind_i       (s1_kind_q),
    .angle_i      (s1_angle_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .unwrapped_o  (unwrapped_angle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_move) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_kind_q    <= mtet_pkg::kind_e'(kind_i);
      s1_angle_q   <= angle_raw_i;
      s1_speed_q   <= speed_raw_i;
      s1_current_q <= current_raw_i;
      s1_status_q  <= status_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_angle_q   <= s1_angle_q;
      out_speed_q   <= s1_speed_q;
      out_current_q <= s1_current_q;
      out_status_q  <= s1_status_q;
      out_turns_q   <= state_d.turns;
      out_total_q   <= unwrapped_angle;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign angle_o           = out_angle_q;
  assign speed_o           = out_speed_q;
  assign current_o         = out_current_q;
  assign status_o          = out_status_q;
  assign turn_count_o      = out_turns_q;
  assign unwrapped_angle_o = out_total_q;

  // The turn counter moves by at most one turn per cycle.
  `MTET_ASSERT(a_turn_step, (state_q.turns != $past(state_q.turns)) |-> ((state_q.turns - $past(state_q.turns)) == 16'sd1 || ($past(state_q.turns) - state_q.turns) == 16'sd1), "turn counter jumped by more than one")
  // A capture transaction never creates a result.
  `MTET_ASSERT(a_capture_silent, (s1_move && !s1_is_meas) |=> (out_valid_q == $past(out_valid_q && out_stall_i)), "capture transaction produced a result")
  // The offset only changes when a capture transaction completes.
  `MTET_ASSERT(a_offset_on_capture, (state_q.zero_angle != $past(state_q.zero_angle)) |-> $past(s1_move && !s1_is_meas), "offset changed without a capture")
  // Backpressure only appears while the input register is occupied.
  `MTET_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> s1_valid_q, "input stalled with empty input register")

endmodule

// File: dv/multi_turn_encoder_tracker_core_tb.sv
`timescale 1ns / 1ps

module multi_turn_encoder_tracker_core_tb;

  localparam int COUNTS_PER_TURN = mtet_pkg::CountsPerTurnDefault;
  localparam int HALF_TURN = COUNTS_PER_TURN / 2;

  // A receiver hold-off this long is enough to fill both pipeline registers
  // and push back on the sender.
  localparam int HOLD_CYCLES = 60;
  // Longest run of cycles without any transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles to keep watching after the last expected reading has arrived.
  localparam int DRAIN_CYCLES = 10;

  typedef logic [mtet_pkg::AngleW-1:0]         angle_t;
  typedef logic signed [mtet_pkg::WordW-1:0]   word_t;
  typedef logic [mtet_pkg::StatusW-1:0]        status_t;
  typedef logic signed [mtet_pkg::TurnsW-1:0]  turns_t;
  typedef logic signed [mtet_pkg::TotalW-1:0]  total_t;

  // One decoded feedback frame, as offered on the input channel.
  typedef struct {
    mtet_pkg::kind_e  kind;
    angle_t           angle;
    word_t            speed;
    word_t            current;
    status_t          status;
  } frame_t;

  // One reading, as expected on the output channel.
  typedef struct {
    angle_t   angle;
    word_t    speed;
    word_t    current;
    status_t  status;
    turns_t   turns;
    total_t   total;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [0:0]  kind_i = mtet_pkg::KIND_MEASURE;
  angle_t      angle_raw_i = '0;
  word_t       speed_raw_i = '0;
  word_t       current_raw_i = '0;
  status_t     status_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  angle_t      angle_o;
  word_t       speed_o;
  word_t       current_o;
  status_t     status_o;
  turns_t      turn_count_o;
  total_t      unwrapped_angle_o;

  multi_turn_encoder_tracker_core #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .angle_raw_i       (angle_raw_i),
    .speed_raw_i       (speed_raw_i),
    .current_raw_i     (current_raw_i),
    .status_byte_i     (status_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .angle_o           (angle_o),
    .speed_o           (speed_o),
    .current_o         (current_o),
    .status_o          (status_o),
    .turn_count_o      (turn_count_o),
    .unwrapped_angle_o (unwrapped_angle_o)
  );

  // Frames waiting to be offered, and readings waiting to be seen.
  frame_t   frame_queue[$];
  reading_t expected_readings[$];

  // Tracker state as the testbench predicts it; reset leaves all of it at zero.
  angle_t trk_prev_angle = '0;
  angle_t trk_offset = '0;
  turns_t trk_turns = '0;

  // Angle of the last frame queued, so that new frames can be placed relative
  // to where the rotor was last reported.
  angle_t gen_prev_angle = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int error_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Updates the predicted tracker state with one accepted frame and, for a
  // measurement, records the reading the block has to produce for it.
  function automatic void track_frame(mtet_pkg::kind_e kind, angle_t angle,
                                      word_t speed, word_t current,
                                      status_t status);
    int       jump;
    longint   unwrapped;
    reading_t r;
    if (kind == mtet_pkg::KIND_CAPTURE) begin
      // An offset capture re-zeroes the total angle and gives no reading.
      trk_offset = angle;
      trk_prev_angle = angle;
    end else begin
      // A jump of more than half a turn can only be a wrap through zero.
      // A jump of exactly half a turn is taken as real motion.
      jump = int'(angle) - int'(trk_prev_angle);
      if (jump > HALF_TURN) begin
        trk_turns = trk_turns - 16'sd1;
      end else if (jump < -HALF_TURN) begin
        trk_turns = trk_turns + 16'sd1;
      end
      trk_prev_angle = angle;
      unwrapped = longint'(trk_turns) * COUNTS_PER_TURN + longint'(angle)
                  - longint'(trk_offset);
      r.angle = angle;
      r.speed = speed;
      r.current = current;
      r.status = status;
      r.turns = trk_turns;
      r.total = unwrapped[mtet_pkg::TotalW-1:0];
      expected_readings.push_back(r);
    end
  endfunction

  function automatic void queue_frame(mtet_pkg::kind_e kind, angle_t angle,
                                      word_t speed, word_t current,
                                      status_t status);
    frame_t f;
    f.kind = kind;
    f.angle = angle;
    f.speed = speed;
    f.current = current;
    f.status = status;
    frame_queue.push_back(f);
    gen_prev_angle = angle;
  endfunction

  // Random frames. In equal shares they move the rotor by a plausible amount,
  // land right at the half-turn boundary, wrap through zero, or jump anywhere.
  // About one in ten is an offset capture.
  function automatic void queue_random_frames(int count);
    mtet_pkg::kind_e kind;
    int              delta;
    repeat (count) begin
      kind = ($urandom_range(9) == 0) ? mtet_pkg::KIND_CAPTURE : mtet_pkg::KIND_MEASURE;
      case ($urandom_range(3))
        0: delta = int'($urandom_range(COUNTS_PER_TURN - 1));
        1: delta = int'($urandom_range(400)) - 200;
        2: delta = HALF_TURN - 2 + int'($urandom_range(4));
        default: delta = HALF_TURN + 1 + int'($urandom_range(HALF_TURN - 2));
      endcase
      if ($urandom_range(1) == 1) begin
        delta = -delta;
      end
      queue_frame(kind, angle_t'(int'(gen_prev_angle) + delta), word_t'($urandom),
                  word_t'($urandom), status_t'($urandom));
    end
  endfunction

  // Blocks until every queued frame has been taken and every expected reading
  // has been checked. Sampled at the falling edge, clear of the clocked logic.
  task automatic wait_until_drained();
    do begin
      @(negedge clk_i);
    end while (frame_queue.size() != 0 || in_valid_i || expected_readings.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Sender. A new frame is put on the bus only once the previous transaction
  // has completed; a stalled frame is held unchanged. Idle cycles are
  // inserted at random at the rate set for the current phase.
  always @(posedge clk_i) begin : drive_frames
    frame_t f;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        f = frame_queue.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= f.kind;
        angle_raw_i <= f.angle;
        speed_raw_i <= f.speed;
        current_raw_i <= f.current;
        status_byte_i <= f.status;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver. A requested hold-off stalls the output until its countdown runs
  // out; otherwise the stall is random at the rate of the current phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every accepted input transaction goes through the predictor, which is
  // fed from the port values as the block saw them at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      track_frame(mtet_pkg::kind_e'(kind_i), angle_raw_i, speed_raw_i, current_raw_i,
                  status_byte_i);
    end
  end

  // Every accepted output transaction is matched against the oldest
  // outstanding expectation.
  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading: expected none, got angle %0h turns %0h total %0h",
                 $time, angle_o, turn_count_o, unwrapped_angle_o);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("angle", 32'(want.angle), 32'(angle_o));
        check_field("speed", 32'(want.speed), 32'(speed_o));
        check_field("current", 32'(want.current), 32'(current_o));
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("turn_count", 32'(want.turns), 32'(turn_count_o));
        check_field("unwrapped_angle", 32'(want.total), 32'(unwrapped_angle_o));
      end
    end
  end

  // Hang detection: too long without a transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL multi_turn_encoder_tracker_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(negedge clk_i);

    // First phase: the sender idles less often than the receiver.
    send_idle_pct = 38;
    recv_idle_pct = 56;

    // Directed frames. From reset the previous angle and offset are zero.
    queue_frame(mtet_pkg::KIND_MEASURE, 13'd0, 16'sd0, 16'sd0, 8'h00);
    // Full-scale jumps in both directions, with extreme pass-through values.
    queue_frame(mtet_pkg::KIND_MEASURE, 13'd8191, 16'sh7fff, 16'sh8000, 8'hff);
    queue_frame(mtet_pkg::KIND_MEASURE, 13'd0, 16'sh8000, 16'sh7fff, 8'haa);
    // Exactly half a turn up and back down must not count a turn.
    queue_frame(mtet_pkg::KIND_MEASURE, angle_t'(HALF_TURN), 16'sh5555, 16'shaaaa, 8'h55);
    queue_frame(mtet_pkg::KIND_MEASURE, 13'd0, 16'shaaaa, 16'sh5555, 8'h01);
    // One count past half a turn does count, in either direction.
    queue_frame(mtet_pkg::KIND_MEASURE, angle_t'(HALF_TURN + 1), 16'sd1, -16'sd1, 8'h80);
    queue_frame(mtet_pkg::KIND_MEASURE, 13'd0, -16'sd1, 16'sd1, 8'h7f);
    // An offset capture gives no reading and re-zeroes the total angle.
    queue_frame(mtet_pkg::KIND_CAPTURE, 13'd1000, 16'sh1234, 16'sh4321, 8'h3c);
    queue_frame(mtet_pkg::KIND_MEASURE, 13'd1000, 16'sd100, -16'sd100, 8'hc3);
    queue_frame(mtet_pkg::KIND_MEASURE, angle_t'(1000 + HALF_TURN + 1), 16'sd200, 16'sd300,
                8'h0f);
    // Offsets at both ends of the range, captures back to back.
    queue_frame(mtet_pkg::KIND_CAPTURE, 13'd8191, 16'sh7fff, 16'sh7fff, 8'hff);
    queue_frame(mtet_pkg::KIND_MEASURE, 13'd0, 16'sh0000, 16'shffff, 8'hf0);
    queue_frame(mtet_pkg::KIND_CAPTURE, 13'd4095, 16'sh8000, 16'sh8000, 8'h00);
    queue_frame(mtet_pkg::KIND_CAPTURE, 13'd0, 16'sh00ff, 16'shff00, 8'h00);
    queue_frame(mtet_pkg::KIND_MEASURE, 13'd8191, -16'sd1, 16'sd1, 8'h55);
    queue_frame(mtet_pkg::KIND_MEASURE, 13'd1, 16'sd0, 16'sd0, 8'hff);

    queue_random_frames(130);
    wait_until_drained();

    // Second phase: the receiver is now the faster side.
    send_idle_pct = 56;
    recv_idle_pct = 38;
    queue_random_frames(130);
    wait_until_drained();

    // Third phase: no random idling. The receiver first holds off for a long
    // stretch while the sender keeps offering, so the block fills and stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_requested = holds_requested + 1;
    queue_random_frames(140);
    wait_until_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_readings.size() != 0) begin
      $display("%0t: %0d expected readings never arrived", $time, expected_readings.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS multi_turn_encoder_tracker_core");
    end else begin
      $display("FAIL multi_turn_encoder_tracker_core");
    end
    $finish;
  end

endmodule
